// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: hdl/ple_pkg.sv
`timescale 1ns / 1ps

package ple_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 5;
  localparam int LEN_W    = 5;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_REAR  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_REAR  = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_DUMP      = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OOB   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } fsm_e;

  typedef struct packed {
    cmd_e                     command;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } in_beat_t;

  typedef struct packed {
    status_e                  status;
    logic [LEN_W-1:0]         length;
    logic signed [DATA_W-1:0] element;
    logic                     element_valid;
    logic                     last;
  } out_beat_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic              ins;
    logic              del;
    logic              rot;
    logic [CMP_W-1:0]  pos;
    logic [CMP_W-1:0]  cnt;
    logic [DATA_W-1:0] value;
  } chain_ctl_t;

endpackage

// File: hdl/positional_list_engine.sv
`timescale 1ns / 1ps
// Edits: an accepted beat's result is in the output register in the next cycle.
// Dump: one result beat per entry, one per cycle while the output side takes
// beats, as the chain rotates by one cell for each beat; the next command is
// taken at the earliest at the edge where the last dump beat leaves.
// Throughput: one edit per cycle while the output side takes beats.
// Reset (async, active low) clears the length and control; cell data is not cleared.

module positional_list_engine import ple_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  chain_ctl_t        ctl;
  logic [DATA_W-1:0] cell_data [CAPACITY];

  ple_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .head_i      (cell_data[0]),
    .ctl_o       (ctl)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] left, right;
    // end cells are tied to their own data on the side with no neighbor
    if (g == 0) begin : g_first
      assign left = cell_data[g];
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = cell_data[g];
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end

    ple_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(g)),
      .ctl_i   (ctl),
      .left_i  (left),
      .right_i (right),
      .head_i  (cell_data[0]),
      .data_o  (cell_data[g])
    );
  end

endmodule

// File: hdl/ple_cell.sv
`timescale 1ns / 1ps

module ple_cell import ple_pkg::*; (
  input  logic              clk_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  chain_ctl_t        ctl_i,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  input  logic [DATA_W-1:0] head_i,
  output logic [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] data_q, data_d;
  logic [CMP_W-1:0]  idx_ext;
  logic [CMP_W-1:0]  idx_nxt;

  assign idx_ext = CMP_W'(idx_i);
  assign idx_nxt = idx_ext + 1'b1;

  always_comb begin
    data_d = data_q;
    if (ctl_i.ins) begin
      if (idx_ext > ctl_i.pos) begin
        data_d = left_i;
      end else if (idx_ext == ctl_i.pos) begin
        data_d = ctl_i.value;
      end
    end else if (ctl_i.del) begin
      if (idx_ext >= ctl_i.pos) begin
        data_d = right_i;
      end
    end else if (ctl_i.rot) begin
      // rotate the occupied part by one: the tail cell takes the head
      if (idx_nxt == ctl_i.cnt) begin
        data_d = head_i;
      end else if (idx_nxt < ctl_i.cnt) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// File: hdl/ple_ctrl.sv
`timescale 1ns / 1ps

module ple_ctrl import ple_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_beat_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_beat_t         out_data_o,
  input  logic [DATA_W-1:0] head_i,
  output chain_ctl_t        ctl_o
);

  fsm_e             state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  out_beat_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic             free;
  logic             acc;
  logic             is_ins, is_del, is_dump;
  logic [CMP_W-1:0] pos;
  logic [CMP_W-1:0] cnt_ext;
  status_e          status;
  logic             edit_ok;

  assign cnt_ext    = CMP_W'(count_q);
  assign free       = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && free;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc && is_dump && (count_q > CNT_W'(1))) begin
          state_d = S_DUMP;
        end
      end
      S_DUMP: begin
        if (free && (rem_q == CNT_W'(1))) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    is_ins     = 1'b0;
    is_del     = 1'b0;
    is_dump    = 1'b0;
    pos        = '0;
    case (in_data_i.command)
      CMD_INS_FRONT: is_ins = 1'b1;
      CMD_INS_REAR: begin
        is_ins = 1'b1;
        pos    = cnt_ext;
      end
      CMD_INS_AT: begin
        is_ins = 1'b1;
        pos    = CMP_W'(in_data_i.position);
      end
      CMD_DEL_FRONT: is_del = 1'b1;
      CMD_DEL_REAR: begin
        is_del = 1'b1;
        pos    = cnt_ext - 1'b1;
      end
      CMD_DEL_AT: begin
        is_del = 1'b1;
        pos    = CMP_W'(in_data_i.position);
      end
      CMD_DUMP: is_dump = 1'b1;
      default: ;
    endcase

    status = ST_OK;
    if (is_ins) begin
      if (count_q == CNT_W'(CAPACITY)) status = ST_FULL;
      else if (pos > cnt_ext)          status = ST_OOB;
    end else if (is_del) begin
      if (count_q == '0)        status = ST_EMPTY;
      else if (pos >= cnt_ext)  status = ST_OOB;
    end else if (is_dump && (count_q == '0)) begin
      status = ST_EMPTY;
    end
    edit_ok = (status == ST_OK);

    ctl_o.ins   = acc && is_ins && edit_ok;
    ctl_o.del   = acc && is_del && edit_ok;
    ctl_o.rot   = 1'b0;
    ctl_o.pos   = pos;
    ctl_o.cnt   = cnt_ext;
    ctl_o.value = in_data_i.value;

    count_d     = count_q;
    rem_d       = rem_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (state_q == S_DUMP) begin
      if (free) begin
        ctl_o.rot           = 1'b1;
        out_valid_d         = 1'b1;
        out_d.status        = ST_OK;
        out_d.length        = LEN_W'(count_q);
        out_d.element       = head_i;
        out_d.element_valid = 1'b1;
        out_d.last          = (rem_q == CNT_W'(1));
        rem_d               = rem_q - 1'b1;
      end
    end else if (acc) begin
      out_valid_d = 1'b1;
      if (is_dump && (count_q != '0)) begin
        // emit the head beat now, the rest one per cycle while the output side takes beats
        ctl_o.rot           = 1'b1;
        out_d.status        = ST_OK;
        out_d.length        = LEN_W'(count_q);
        out_d.element       = head_i;
        out_d.element_valid = 1'b1;
        out_d.last          = (count_q == CNT_W'(1));
        rem_d               = count_q - 1'b1;
      end else begin
        if (ctl_o.ins) count_d = count_q + 1'b1;
        if (ctl_o.del) count_d = count_q - 1'b1;
        out_d.status        = status;
        out_d.length        = LEN_W'(count_d);
        out_d.element       = '0;
        out_d.element_valid = 1'b0;
        out_d.last          = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hdl/ple_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ple_checker import ple_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_beat_t out_data_i
);

  // a stalled result beat holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i))

  `ASSERT_IMPLY(a_elem_ok, clk_i, rst_ni, out_valid_i && out_data_i.element_valid, out_data_i.status == ST_OK)

  `ASSERT_IMPLY(a_no_elem_zero, clk_i, rst_ni, out_valid_i && !out_data_i.element_valid, out_data_i.element == '0)

  `ASSERT_IMPLY(a_len_bound, clk_i, rst_ni, out_valid_i, out_data_i.length <= CAPACITY)

  `ASSERT_IMPLY(a_full_len, clk_i, rst_ni, out_valid_i && (out_data_i.status == ST_FULL), out_data_i.length == CAPACITY)

endmodule

bind positional_list_engine ple_checker u_ple_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);
